>>> hdl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared widths, sequencer states and the command/status types that pass
// between the tangent frame controller and its datapath.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int POS_W  = 24;
    localparam int UV_W   = 16;
    localparam int OUT_W  = 16;
    localparam int FRAC_W = OUT_W - 2;

    localparam int E_W    = POS_W + 1;        // edge vector component
    localparam int D_W    = UV_W + 1;         // texcoord delta
    localparam int P_W    = E_W + D_W;        // one product
    localparam int A_W    = P_W + 2;          // difference of products, negated
    localparam int RED_W  = 30;               // magnitudes reduced below 2^30
    localparam int SQ_W   = 2 * RED_W + 2;    // sum of three squares
    localparam int RT_W   = SQ_W + 1;         // root iteration registers
    localparam int N_W    = RED_W + 1;        // integer root
    localparam int REM_W  = N_W + 1;          // divider remainder
    localparam int QB     = FRAC_W + 2;       // quotient bits
    localparam int CNT_W  = 5;

    localparam int IN_DATA_W  = ((3 * POS_W + 2 * UV_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((6 * OUT_W + 7) / 8) * 8;

    localparam int MUL_LAST = 13;             // 14 products per triangle
    localparam int SQ_LAST  = 3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_MUL,
        OP_NEG,
        OP_ABS,
        OP_SHIFT,
        OP_SQ,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_MWAIT,
        ST_NEG,
        ST_ABS,
        ST_SHIFT,
        ST_SQ,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] idx;
        logic             vec;
        logic [1:0]       comp;
    } dp_cmd_t;

    typedef struct packed {
        logic big;
        logic root_done;
    } dp_sts_t;

endpackage

>>> hdl/ttf_datapath.sv
// ----------------------------------------------------------------------------
// ttf_datapath
// Corner hold registers, shared product unit, normalizing shift, bit-pair
// square root, restoring divider and the output register.
// ----------------------------------------------------------------------------
module ttf_datapath (
    input  logic                                aclk,
    input  ttf_pkg::dp_cmd_t                    cmd,
    output ttf_pkg::dp_sts_t                    sts,
    input  logic [ttf_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic [ttf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    logic signed [ttf_pkg::POS_W-1:0] pos_reg [3][3];
    logic signed [ttf_pkg::UV_W-1:0]  tex_reg [3][2];
    logic signed [ttf_pkg::E_W-1:0]   e1_reg [3];
    logic signed [ttf_pkg::E_W-1:0]   e2_reg [3];
    logic signed [ttf_pkg::D_W-1:0]   d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [ttf_pkg::P_W-1:0]   prod_reg;
    logic [2:0]                       prod_dst_reg;
    logic                             prod_sub_reg;
    logic                             prod_vld_reg;
    logic signed [ttf_pkg::A_W-1:0]   acc_reg [7];
    logic [ttf_pkg::A_W-1:0]          mag_reg [3];
    logic [2*ttf_pkg::RED_W-1:0]      sq_reg;
    logic [ttf_pkg::SQ_W-1:0]         s_reg;
    logic [ttf_pkg::RT_W-1:0]         rx_reg, rr_reg, rbit_reg;
    logic [ttf_pkg::REM_W-1:0]        rem_reg;
    logic [ttf_pkg::QB-1:0]           quot_reg;
    logic [ttf_pkg::OUT_W-1:0]        res_reg [6];
    logic [ttf_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic                             out_deg_reg;

    // product operand selection
    logic [2:0]                       pair;
    logic                             second;
    logic [1:0]                       c;
    logic signed [ttf_pkg::D_W-1:0]   mul_a;
    logic signed [ttf_pkg::E_W-1:0]   mul_b;
    logic [2:0]                       mul_dst;
    logic signed [ttf_pkg::P_W-1:0]   prod;

    assign pair   = cmd.idx[3:1];
    assign second = cmd.idx[0];

    always_comb begin
        c       = 2'd0;
        mul_a   = d2v_reg;
        mul_b   = e1_reg[0];
        mul_dst = pair;
        case (pair)
            3'd0, 3'd1, 3'd2: begin
                c     = pair[1:0];
                mul_a = second ? d1v_reg : d2v_reg;
                mul_b = second ? e2_reg[c] : e1_reg[c];
            end
            3'd3, 3'd4, 3'd5: begin
                c     = 2'(pair - 3'd3);
                mul_a = second ? d2u_reg : d1u_reg;
                mul_b = second ? e1_reg[c] : e2_reg[c];
            end
            default: begin
                mul_dst = 3'd6;
                mul_a   = second ? d2u_reg : d1u_reg;
                mul_b   = second
                    ? {{(ttf_pkg::E_W-ttf_pkg::D_W){d1v_reg[ttf_pkg::D_W-1]}}, d1v_reg}
                    : {{(ttf_pkg::E_W-ttf_pkg::D_W){d2v_reg[ttf_pkg::D_W-1]}}, d2v_reg};
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // the three components of the vector being normalized
    logic signed [ttf_pkg::A_W-1:0] vsel [3];
    logic [ttf_pkg::A_W-1:0]        vabs [3];
    logic [ttf_pkg::A_W-1:0]        mag_or;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vsel[i] = cmd.vec ? acc_reg[i+3] : acc_reg[i];
            vabs[i] = vsel[i][ttf_pkg::A_W-1] ? $unsigned(-vsel[i]) : $unsigned(vsel[i]);
        end
    end

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // squarer
    logic [1:0]                   sq_sel;
    logic [ttf_pkg::RED_W-1:0]    sq_op;
    logic [2*ttf_pkg::RED_W-1:0]  sq_prod;

    assign sq_sel  = (cmd.idx[1:0] == 2'd3) ? 2'd0 : cmd.idx[1:0];
    assign sq_op   = mag_reg[sq_sel][ttf_pkg::RED_W-1:0];
    assign sq_prod = sq_op * sq_op;

    // root step
    logic [ttf_pkg::RT_W-1:0] root_trial;
    assign root_trial = rr_reg + rbit_reg;

    // divider
    logic [ttf_pkg::N_W-1:0]   root;
    logic [ttf_pkg::N_W-1:0]   divisor;
    logic [ttf_pkg::REM_W-1:0] div_trial;

    assign root      = rr_reg[ttf_pkg::N_W-1:0];
    assign divisor   = (root == '0) ? ttf_pkg::N_W'(1) : root;
    assign div_trial = (cmd.idx == '0) ? rem_reg : {rem_reg[ttf_pkg::REM_W-2:0], 1'b0};

    // rounding, limit and sign
    logic [ttf_pkg::QB:0]      q_round;
    logic [ttf_pkg::QB-1:0]    q_lim;
    logic [ttf_pkg::OUT_W-1:0] q_out;
    logic [2:0]                res_idx;

    always_comb begin
        q_round = ({1'b0, quot_reg} + 1'b1) >> 1;
        if (q_round > (ttf_pkg::QB+1)'(1 << ttf_pkg::FRAC_W)) begin
            q_lim = ttf_pkg::QB'(1 << ttf_pkg::FRAC_W);
        end else begin
            q_lim = q_round[ttf_pkg::QB-1:0];
        end
        q_out   = vsel[cmd.comp][ttf_pkg::A_W-1] ? ttf_pkg::OUT_W'(-q_lim)
                                                 : ttf_pkg::OUT_W'(q_lim);
        res_idx = cmd.vec ? (3'(cmd.comp) + 3'd3) : 3'(cmd.comp);
    end

    always_ff @(posedge aclk) begin
        prod_vld_reg <= (cmd.op == ttf_pkg::OP_MUL);
        prod_reg     <= prod;
        prod_dst_reg <= mul_dst;
        prod_sub_reg <= second;

        if (prod_vld_reg) begin
            if (prod_sub_reg) begin
                acc_reg[prod_dst_reg] <= acc_reg[prod_dst_reg]
                    - {{(ttf_pkg::A_W-ttf_pkg::P_W){prod_reg[ttf_pkg::P_W-1]}}, prod_reg};
            end else begin
                acc_reg[prod_dst_reg] <=
                    {{(ttf_pkg::A_W-ttf_pkg::P_W){prod_reg[ttf_pkg::P_W-1]}}, prod_reg};
            end
        end

        case (cmd.op)
            ttf_pkg::OP_LOAD: begin
                pos_reg[cmd.idx[1:0]][0] <= s_tdata[ttf_pkg::POS_W-1:0];
                pos_reg[cmd.idx[1:0]][1] <= s_tdata[2*ttf_pkg::POS_W-1:ttf_pkg::POS_W];
                pos_reg[cmd.idx[1:0]][2] <= s_tdata[3*ttf_pkg::POS_W-1:2*ttf_pkg::POS_W];
                tex_reg[cmd.idx[1:0]][0] <=
                    s_tdata[3*ttf_pkg::POS_W+ttf_pkg::UV_W-1:3*ttf_pkg::POS_W];
                tex_reg[cmd.idx[1:0]][1] <=
                    s_tdata[3*ttf_pkg::POS_W+2*ttf_pkg::UV_W-1:
                            3*ttf_pkg::POS_W+ttf_pkg::UV_W];
            end
            ttf_pkg::OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    e1_reg[i] <= ttf_pkg::E_W'(pos_reg[1][i]) - ttf_pkg::E_W'(pos_reg[0][i]);
                    e2_reg[i] <= ttf_pkg::E_W'(pos_reg[2][i]) - ttf_pkg::E_W'(pos_reg[0][i]);
                end
                d1u_reg <= ttf_pkg::D_W'(tex_reg[1][0]) - ttf_pkg::D_W'(tex_reg[0][0]);
                d1v_reg <= ttf_pkg::D_W'(tex_reg[1][1]) - ttf_pkg::D_W'(tex_reg[0][1]);
                d2u_reg <= ttf_pkg::D_W'(tex_reg[2][0]) - ttf_pkg::D_W'(tex_reg[0][0]);
                d2v_reg <= ttf_pkg::D_W'(tex_reg[2][1]) - ttf_pkg::D_W'(tex_reg[0][1]);
            end
            ttf_pkg::OP_NEG: begin
                if (acc_reg[6][ttf_pkg::A_W-1]) begin
                    for (int i = 0; i < 6; i++) begin
                        acc_reg[i] <= -acc_reg[i];
                    end
                end
            end
            ttf_pkg::OP_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= vabs[i];
                end
                s_reg <= '0;
            end
            ttf_pkg::OP_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
            end
            ttf_pkg::OP_SQ: begin
                sq_reg <= sq_prod;
                if (cmd.idx != '0) begin
                    s_reg <= s_reg + ttf_pkg::SQ_W'(sq_reg);
                end
            end
            ttf_pkg::OP_ROOT_INIT: begin
                rx_reg   <= ttf_pkg::RT_W'(s_reg);
                rr_reg   <= '0;
                rbit_reg <= {1'b1, {(ttf_pkg::RT_W-1){1'b0}}};
            end
            ttf_pkg::OP_ROOT_STEP: begin
                if (rx_reg >= root_trial) begin
                    rx_reg <= rx_reg - root_trial;
                    rr_reg <= (rr_reg >> 1) + rbit_reg;
                end else begin
                    rr_reg <= rr_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            ttf_pkg::OP_DIV_INIT: begin
                rem_reg  <= mag_reg[cmd.comp][ttf_pkg::REM_W-1:0];
                quot_reg <= '0;
            end
            ttf_pkg::OP_DIV_STEP: begin
                if (div_trial >= ttf_pkg::REM_W'(divisor)) begin
                    rem_reg  <= div_trial - ttf_pkg::REM_W'(divisor);
                    quot_reg <= {quot_reg[ttf_pkg::QB-2:0], 1'b1};
                end else begin
                    rem_reg  <= div_trial;
                    quot_reg <= {quot_reg[ttf_pkg::QB-2:0], 1'b0};
                end
            end
            ttf_pkg::OP_DIV_DONE: begin
                res_reg[res_idx] <= q_out;
            end
            ttf_pkg::OP_OUT_LOAD: begin
                out_data_reg <= ttf_pkg::OUT_DATA_W'({res_reg[5], res_reg[4], res_reg[3],
                                                      res_reg[2], res_reg[1], res_reg[0]});
                out_deg_reg  <= (acc_reg[6] == '0);
            end
            default: begin
            end
        endcase
    end

    assign sts.big       = |mag_or[ttf_pkg::A_W-1:ttf_pkg::RED_W];
    assign sts.root_done = (rbit_reg == '0);
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_deg_reg;

endmodule

>>> hdl/ttf_controller.sv
// ----------------------------------------------------------------------------
// ttf_controller
// Sequencer: counts corners, steps the datapath through products, sign fix,
// reduction, root and division for both vectors, and owns the result valid.
// ----------------------------------------------------------------------------
module ttf_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ttf_pkg::dp_sts_t  sts,
    output ttf_pkg::dp_cmd_t  cmd
);

    ttf_pkg::ctl_state_t       state_reg, state_next;
    logic [ttf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      vec_reg, vec_next;
    logic [1:0]                comp_reg, comp_next;
    logic [1:0]                corner_reg, corner_next;
    logic                      out_vld_reg, out_vld_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttf_pkg::ST_IDLE;
            cnt_reg     <= '0;
            vec_reg     <= 1'b0;
            comp_reg    <= 2'd0;
            corner_reg  <= 2'd0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            vec_reg     <= vec_next;
            comp_reg    <= comp_next;
            corner_reg  <= corner_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        vec_next     = vec_reg;
        comp_next    = comp_reg;
        corner_next  = corner_reg;
        out_vld_next = out_vld_reg && !m_tready;
        s_tready     = 1'b0;
        cmd.op       = ttf_pkg::OP_NOP;
        cmd.idx      = cnt_reg;
        cmd.vec      = vec_reg;
        cmd.comp     = comp_reg;

        case (state_reg)
            ttf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.idx  = ttf_pkg::CNT_W'(corner_reg);
                if (s_tvalid) begin
                    cmd.op = ttf_pkg::OP_LOAD;
                    if (corner_reg == 2'd2) begin
                        corner_next = 2'd0;
                        state_next  = ttf_pkg::ST_DIFF;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            ttf_pkg::ST_DIFF: begin
                cmd.op     = ttf_pkg::OP_DIFF;
                cnt_next   = '0;
                state_next = ttf_pkg::ST_MUL;
            end
            ttf_pkg::ST_MUL: begin
                cmd.op = ttf_pkg::OP_MUL;
                if (cnt_reg == ttf_pkg::CNT_W'(ttf_pkg::MUL_LAST)) begin
                    state_next = ttf_pkg::ST_MWAIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ttf_pkg::ST_MWAIT: begin
                // last product lands in the accumulator here
                state_next = ttf_pkg::ST_NEG;
            end
            ttf_pkg::ST_NEG: begin
                cmd.op     = ttf_pkg::OP_NEG;
                vec_next   = 1'b0;
                state_next = ttf_pkg::ST_ABS;
            end
            ttf_pkg::ST_ABS: begin
                cmd.op     = ttf_pkg::OP_ABS;
                state_next = ttf_pkg::ST_SHIFT;
            end
            ttf_pkg::ST_SHIFT: begin
                if (sts.big) begin
                    cmd.op = ttf_pkg::OP_SHIFT;
                end else begin
                    cnt_next   = '0;
                    state_next = ttf_pkg::ST_SQ;
                end
            end
            ttf_pkg::ST_SQ: begin
                cmd.op = ttf_pkg::OP_SQ;
                if (cnt_reg == ttf_pkg::CNT_W'(ttf_pkg::SQ_LAST)) begin
                    state_next = ttf_pkg::ST_ROOT_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ttf_pkg::ST_ROOT_INIT: begin
                cmd.op     = ttf_pkg::OP_ROOT_INIT;
                state_next = ttf_pkg::ST_ROOT;
            end
            ttf_pkg::ST_ROOT: begin
                if (sts.root_done) begin
                    comp_next  = 2'd0;
                    state_next = ttf_pkg::ST_DIV_INIT;
                end else begin
                    cmd.op = ttf_pkg::OP_ROOT_STEP;
                end
            end
            ttf_pkg::ST_DIV_INIT: begin
                cmd.op     = ttf_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ttf_pkg::ST_DIV;
            end
            ttf_pkg::ST_DIV: begin
                cmd.op = ttf_pkg::OP_DIV_STEP;
                if (cnt_reg == ttf_pkg::CNT_W'(ttf_pkg::QB - 1)) begin
                    state_next = ttf_pkg::ST_DIV_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ttf_pkg::ST_DIV_DONE: begin
                cmd.op = ttf_pkg::OP_DIV_DONE;
                if (comp_reg == 2'd2) begin
                    if (vec_reg) begin
                        state_next = ttf_pkg::ST_OUT;
                    end else begin
                        vec_next   = 1'b1;
                        state_next = ttf_pkg::ST_ABS;
                    end
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ttf_pkg::ST_DIV_INIT;
                end
            end
            ttf_pkg::ST_OUT: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.op       = ttf_pkg::OP_OUT_LOAD;
                    out_vld_next = 1'b1;
                    state_next   = ttf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;

endmodule

>>> hdl/triangle_tangent_frame_core.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame_core
// Per-triangle unit tangent and bitangent from three streamed corners.
// ----------------------------------------------------------------------------
// Corners 1 and 2 are only held; the third corner starts the solve: products
// and sign fix, then per vector the normalizing shifts, the 32-step root and
// three 16-step divides, into the result register. One triangle in flight at a
// time; a waiting result does not block the next corners. Reset clears the
// corner count and the result valid; held corners are not cleared.
module triangle_tangent_frame_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], tex_u[87:72], tex_v[103:88]
    input  logic [ttf_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tangent_x/y/z [47:0], bitangent_x/y/z [95:48], 16 bits each
    output logic [ttf_pkg::OUT_DATA_W-1:0]    m_tdata,
    // degenerate_uv [0]
    output logic [0:0]                        m_tuser
);

    ttf_pkg::dp_cmd_t cmd;
    ttf_pkg::dp_sts_t sts;
    logic             deg;

    ttf_controller u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttf_datapath u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (deg)
    );

    assign m_tuser[0] = deg;

endmodule

>>> sim/ttf_checker.sv
// ----------------------------------------------------------------------------
// ttf_checker
// Watches the corner and result channels of triangle_tangent_frame_core,
// predicts each tangent frame from accepted corners and compares results.
// ----------------------------------------------------------------------------
module ttf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ttf_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ttf_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]                     m_tuser,
    output int                             fail_count,
    output int                             pending
);
    import ttf_pkg::*;

    typedef struct packed {
        logic                  degenerate;
        logic [OUT_DATA_W-1:0] frame;
    } frame_t;

    frame_t            frame_q[$];
    logic [POS_W-1:0]  corner_pos[2][3];
    logic [UV_W-1:0]   corner_uv[2][2];
    int                corner_cnt;

    assign pending = frame_q.size();

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [3*OUT_W-1:0] unit_vector(longint c0, longint c1, longint c2);
        longint          c[3];
        longint unsigned mag[3], mx, s, n, q;
        logic [3*OUT_W-1:0] res;
        int k;
        c[0] = c0; c[1] = c1; c[2] = c2;
        mx = 0; s = 0; k = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? -c[i] : c[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) return res;
        while ((mx >> k) >= (64'd1 << RED_W)) k++;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= k;
            s += mag[i] * mag[i];
        end
        n = root64(s);
        if (n == 0) n = 1;
        for (int i = 0; i < 3; i++) begin
            q = (((mag[i] << (FRAC_W + 1)) / n) + 1) >> 1;
            if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
            if (c[i] < 0) q = -q;
            res[i*OUT_W +: OUT_W] = q[OUT_W-1:0];
        end
        return res;
    endfunction

    task automatic take_corner(logic [IN_DATA_W-1:0] d);
        longint p[3][3], t[3][2], e1[3], e2[3], tg[3], bt[3];
        longint d1u, d1v, d2u, d2v, det;
        frame_t f;
        if (corner_cnt < 2) begin
            for (int i = 0; i < 3; i++) corner_pos[corner_cnt][i] = d[i*POS_W +: POS_W];
            corner_uv[corner_cnt][0] = d[3*POS_W +: UV_W];
            corner_uv[corner_cnt][1] = d[3*POS_W+UV_W +: UV_W];
            corner_cnt++;
            return;
        end
        corner_cnt = 0;
        for (int i = 0; i < 3; i++) begin
            p[0][i] = $signed(corner_pos[0][i]);
            p[1][i] = $signed(corner_pos[1][i]);
            p[2][i] = $signed(d[i*POS_W +: POS_W]);
        end
        for (int i = 0; i < 2; i++) begin
            t[0][i] = $signed(corner_uv[0][i]);
            t[1][i] = $signed(corner_uv[1][i]);
            t[2][i] = $signed(d[3*POS_W+i*UV_W +: UV_W]);
        end
        d1u = t[1][0] - t[0][0];
        d1v = t[1][1] - t[0][1];
        d2u = t[2][0] - t[0][0];
        d2v = t[2][1] - t[0][1];
        det = d1u * d2v - d2u * d1v;
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[1][i] - p[0][i];
            e2[i] = p[2][i] - p[0][i];
            tg[i] = d2v * e1[i] - d1v * e2[i];
            bt[i] = d1u * e2[i] - d2u * e1[i];
            if (det < 0) begin
                tg[i] = -tg[i];
                bt[i] = -bt[i];
            end
        end
        f.frame = '0;
        f.frame[3*OUT_W-1:0]       = unit_vector(tg[0], tg[1], tg[2]);
        f.frame[6*OUT_W-1:3*OUT_W] = unit_vector(bt[0], bt[1], bt[2]);
        f.degenerate = (det == 0);
        frame_q.push_back(f);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            corner_cnt <= 0;
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) take_corner(s_tdata);
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected frame %h deg %b", $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    frame_t f;
                    f = frame_q.pop_front();
                    if (f.frame !== m_tdata || f.degenerate !== m_tuser[0]) begin
                        $display("%0t: frame mismatch expected %h deg %b, got %h deg %b",
                                 $time, f.frame, f.degenerate, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb_triangle_tangent_frame_core.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_frame_core
// Streams triangle corners into the core with bursty sending and a stalling
// receiver; the checker predicts and compares every tangent frame.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_frame_core;
    import ttf_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    int                    fail_count, pending;
    int                    idle_cycles = 0;
    logic                  quiet = 1'b0;

    always #10 aclk = ~aclk;

    triangle_tangent_frame_core u_dut (.*);

    ttf_checker u_chk (.*);

    // receiver stall pattern: runs of ready and stall of varying length
    always @(negedge aclk) begin
        if (quiet) m_tready <= 1'b1;
        else case ($urandom_range(0, 3))
            0:       m_tready <= 1'b0;
            1:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("triangle_tangent_frame_core test failed");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] make_corner(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
            logic [POS_W-1:0] z, logic [UV_W-1:0] u, logic [UV_W-1:0] v);
        make_corner = '0;
        make_corner[3*POS_W+2*UV_W-1:0] = {v, u, z, y, x};
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(POS_W-1){1'b1}}};
            1:       return {1'b1, {(POS_W-1){1'b0}}};
            2:       return POS_W'($signed($urandom_range(0, 64)) - 32);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [UV_W-1:0] rand_uv();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(UV_W-1){1'b1}}};
            1:       return {1'b1, {(UV_W-1){1'b0}}};
            2:       return UV_W'($signed($urandom_range(0, 8)) - 4);
            default: return UV_W'($urandom);
        endcase
    endfunction

    task automatic send_corner(logic [IN_DATA_W-1:0] d);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if ($urandom_range(0, 3) == 0) s_tvalid <= 1'b0;
    endtask

    localparam logic [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [UV_W-1:0]  UMAX = {1'b0, {(UV_W-1){1'b1}}};
    localparam logic [UV_W-1:0]  UMIN = {1'b1, {(UV_W-1){1'b0}}};

    initial begin
        logic [UV_W-1:0] u0, v0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // ordinary right triangle
        send_corner(make_corner(0, 0, 0, 0, 0));
        send_corner(make_corner(256, 0, 0, 4096, 0));
        send_corner(make_corner(0, 256, 0, 0, 4096));
        // mirrored uv: negative determinant
        send_corner(make_corner(0, 0, 0, 0, 0));
        send_corner(make_corner(256, 0, 0, 0, 4096));
        send_corner(make_corner(0, 256, 0, 4096, 0));
        // same uv everywhere: zero determinant and zero vectors
        send_corner(make_corner(5, 6, 7, 100, 100));
        send_corner(make_corner(PMAX, 3, 9, 100, 100));
        send_corner(make_corner(PMIN, 1, 2, 100, 100));
        // extremes: largest edges and deltas
        send_corner(make_corner(PMIN, PMAX, PMIN, UMIN, UMAX));
        send_corner(make_corner(PMAX, PMIN, PMAX, UMAX, UMIN));
        send_corner(make_corner(PMAX, PMAX, PMIN, UMIN, UMIN));
        send_corner(make_corner(PMAX, PMAX, PMAX, UMAX, UMAX));
        send_corner(make_corner(PMIN, PMIN, PMIN, UMIN, UMAX));
        send_corner(make_corner(PMAX, PMIN, 0, UMAX, UMIN));
        // coincident corners: zero position edges with distinct uv
        send_corner(make_corner(0, 0, 0, 0, 0));
        send_corner(make_corner(0, 0, 0, 4096, 0));
        send_corner(make_corner(0, 0, 0, 0, 4096));
        for (int i = 0; i < 830; i += 3) begin
            if (i == 400) quiet = 1'b1;
            if (i == 560) quiet = 1'b0;
            u0 = rand_uv();
            v0 = rand_uv();
            send_corner(make_corner(rand_pos(), rand_pos(), rand_pos(), u0, v0));
            if ($urandom_range(0, 9) == 0) begin
                // degenerate texture: repeat first uv
                send_corner(make_corner(rand_pos(), rand_pos(), rand_pos(), u0, v0));
            end else begin
                send_corner(make_corner(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv()));
            end
            send_corner(make_corner(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv()));
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("triangle_tangent_frame_core test passed");
        end else begin
            $display("triangle_tangent_frame_core test failed");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/ttf_pkg.sv
hdl/ttf_datapath.sv
hdl/ttf_controller.sv
hdl/triangle_tangent_frame_core.sv
sim/ttf_checker.sv
sim/tb_triangle_tangent_frame_core.sv
